/* src/trfd_pkg.sv */
package trfd_pkg;

  // Default sizes
  localparam int MAX_RUNS_DEF   = 64;
  localparam int FRAME_BITS_DEF = 64;

  // Pre-sync sliding window
  localparam int WIN_RUNS = 4;

  // Saturation limit of run counts and bit total
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [15:0] THR_RST      = 16'd0;
  localparam logic [15:0] MIN_SPK_RST  = 16'd2;
  localparam logic [15:0] MAX_SPK_RST  = 16'd30;
  localparam logic [7:0]  ZERO_LEN_RST = 8'd5;
  localparam logic [7:0]  ONE_LEN_RST  = 8'd4;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_MIN_SPIKE_LEN   = 3'd1,
    REG_MAX_SPIKE_LEN   = 3'd2,
    REG_ZERO_BIT_LEN    = 3'd3,
    REG_ONE_BIT_LEN     = 3'd4
  } reg_idx_t;

  // Command codes
  typedef enum logic {
    CMD_FEED = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] sample;
  } req_t;

  typedef struct packed {
    logic        synced;
    logic [15:0] bit_count;
    logic        run_overflow;
    logic [63:0] frame_bits;
    logic [6:0]  frame_len;
  } rsp_t;

endpackage

/* src/threshold_run_frame_detector_top.sv */
// Flow per accepted item: a read walks the stored runs through the divider into the frame.
// After sync, an extending sample with over two runs may merge a short middle run, and the
// bit total is walked anew after a merge, when a run length reaches a multiple of ten and
// before a new run is appended; before sync a new run is checked, and the window copied at sync.
// One item at a time, the next taken when the result turns valid; shared divider paces each walk.
// Reset (rst, sync, active high) clears run count, flags, total and registers; store not cleared.
module threshold_run_frame_detector_top
  import trfd_pkg::*;
#(
  parameter int MAX_RUNS   = MAX_RUNS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_RUNS);
  localparam int NW = $clog2(MAX_RUNS + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_MW1    = 12'b000000000010,
    S_MW2    = 12'b000000000100,
    S_MW3    = 12'b000000001000,
    S_DIV    = 12'b000000010000,
    S_WT     = 12'b000000100000,
    S_LD     = 12'b000001000000,
    S_ACC    = 12'b000010000000,
    S_APPEND = 12'b000100000000,
    S_SYNC   = 12'b001000000000,
    S_COPY   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] thr, min_spk, max_spk;
  logic [7:0]  zero_len, one_len;

  // Run state
  logic [NW-1:0] n;
  logic          sync, ovf;
  logic [15:0]   total;
  logic [15:0]   last_len;
  logic          last_lvl;
  logic [3:0]    last_mod;
  logic [15:0]   win_len [WIN_RUNS];
  logic          win_lvl [WIN_RUNS];

  // Item context
  logic        is_read, app, div_mod, in_lvl;
  logic [15:0] m2_len;

  // Walk state
  logic [IW-1:0] ra, idx;
  logic [16:0]   rd_q, win_q;
  logic [15:0]   sum;
  logic [63:0]   acc;
  logic [6:0]    pos;
  logic          cur_lvl;

  // Divider
  logic [9:0]  dv_rem;
  logic [17:0] dv_quo;
  logic [8:0]  dv_den;
  logic [4:0]  dv_cnt;

  // Output register
  rsp_t rsp_q;
  logic rsp_v;

  // Run store
  logic [16:0] mem [MAX_RUNS];
  logic        mem_we;
  logic [IW-1:0] mem_wa;
  logic [16:0] mem_wd;

  // APB
  assign pready = 1'b1;
  wire cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_LEVEL_THRESHOLD: prdata = {16'd0, thr};
      REG_MIN_SPIKE_LEN:   prdata = {16'd0, min_spk};
      REG_MAX_SPIKE_LEN:   prdata = {16'd0, max_spk};
      REG_ZERO_BIT_LEN:    prdata = {24'd0, zero_len};
      REG_ONE_BIT_LEN:     prdata = {24'd0, one_len};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= THR_RST;
      min_spk  <= MIN_SPK_RST;
      max_spk  <= MAX_SPK_RST;
      zero_len <= ZERO_LEN_RST;
      one_len  <= ONE_LEN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_LEVEL_THRESHOLD: thr      <= pwdata[15:0];
        REG_MIN_SPIKE_LEN:   min_spk  <= pwdata[15:0];
        REG_MAX_SPIKE_LEN:   max_spk  <= pwdata[15:0];
        REG_ZERO_BIT_LEN:    zero_len <= pwdata[7:0];
        REG_ONE_BIT_LEN:     one_len  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign req_stall = (state != S_IDLE);
  wire   req_acc   = req_valid && !req_stall;
  assign rsp_valid = rsp_v;
  assign rsp       = rsp_q;

  // Accept-time decode of a sample
  wire        s_lvl  = (req.sample > thr);
  wire        same   = (n != '0) && (last_lvl == s_lvl);
  wire        mw_go  = (req.cmd == CMD_FEED) && same && sync && (n > NW'(2));
  wire [15:0] inc_len = (last_len == COUNT_MAX) ? last_len : last_len + 16'd1;
  wire [3:0]  inc_mod = (last_len == COUNT_MAX) ? last_mod :
                        ((last_mod == 4'd9) ? 4'd0 : last_mod + 4'd1);
  wire [IW-1:0] n_m1 = IW'(n - NW'(1));
  wire [IW-1:0] n_m2 = IW'(n - NW'(2));
  wire [IW-1:0] n_m3 = IW'(n - NW'(3));
  wire [1:0]    wn_m1 = 2'(n - NW'(1));

  // Merge sum of the last three runs
  wire [17:0] msum = {2'd0, rd_q[15:0]} + {2'd0, m2_len} + {2'd0, last_len};
  wire [15:0] msat = (msum > {2'd0, COUNT_MAX}) ? COUNT_MAX : msum[15:0];

  // Preamble check on the window
  function automatic logic spk_ok(input logic [15:0] c, input logic [15:0] lo,
                                  input logic [15:0] hi);
    spk_ok = (c > lo) && (c < hi);
  endfunction

  wire sync_hit = (n == NW'(WIN_RUNS)) && win_lvl[0] && !win_lvl[1] && win_lvl[2] &&
                  spk_ok(win_len[0], min_spk, max_spk) &&
                  spk_ok(win_len[1], min_spk, max_spk) &&
                  spk_ok(win_len[2], min_spk, max_spk);

  // Run data seen by the walk
  wire [16:0] src    = sync ? rd_q : win_q;
  wire [7:0]  blen_r = src[16] ? one_len : zero_len;
  wire [7:0]  blen   = (blen_r == 8'd0) ? 8'd1 : blen_r;

  // One restoring step of the divider
  wire [9:0] dv_t   = {dv_rem[8:0], dv_quo[17]};
  wire       dv_ge  = (dv_t >= {1'b0, dv_den});
  wire [9:0] dv_rn  = dv_ge ? dv_t - {1'b0, dv_den} : dv_t;
  wire [17:0] dv_qn = {dv_quo[16:0], dv_ge};

  // Accumulate one run's bits
  wire [15:0] q      = dv_quo[15:0];
  wire [6:0]  room   = 7'(FRAME_BITS) - pos;
  wire [6:0]  nb     = (q > {9'd0, room}) ? room : q[6:0];
  wire [64:0] ones   = (65'd1 << nb) - 65'd1;
  wire [63:0] fmask  = ones[63:0] << pos;
  wire [6:0]  pos_n  = pos + nb;
  wire [16:0] sum_w  = {1'b0, sum} + {1'b0, q};
  wire [15:0] sum_n  = sum_w[16] ? COUNT_MAX : sum_w[15:0];
  wire        w_last = (NW'(idx) + NW'(1)) >= n ||
                       (is_read && pos_n >= 7'(FRAME_BITS));
  wire        can_out = !rsp_v || !rsp_stall;

  // Run store write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = n_m1;
    mem_wd = {in_lvl, 16'd1};
    priority case (1'b1)
      state == S_IDLE && req_acc && req.cmd == CMD_FEED && same && sync: begin
        mem_we = 1'b1;
        mem_wa = n_m1;
        mem_wd = {s_lvl, inc_len};
      end
      state == S_MW3 && m2_len < min_spk: begin
        mem_we = 1'b1;
        mem_wa = n_m3;
        mem_wd = {rd_q[16], msat};
      end
      state == S_APPEND && n < NW'(MAX_RUNS): begin
        mem_we = 1'b1;
        mem_wa = IW'(n);
        mem_wd = {in_lvl, 16'd1};
      end
      state == S_COPY: begin
        mem_we = 1'b1;
        mem_wa = ra;
        mem_wd = {win_lvl[ra[1:0]], win_len[ra[1:0]]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q  <= mem[ra];
    win_q <= {win_lvl[ra[1:0]], win_len[ra[1:0]]};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      sync  <= 1'b0;
      ovf   <= 1'b0;
      total <= 16'd0;
      rsp_v <= 1'b0;
    end else begin
      // Result valid: set when a new result is registered, cleared once taken
      if (state == S_DONE && can_out) begin
        rsp_v <= 1'b1;
      end else if (rsp_v && !rsp_stall) begin
        rsp_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            in_lvl  <= s_lvl;
            is_read <= (req.cmd == CMD_READ);
            app     <= 1'b0;
            div_mod <= 1'b0;
            idx     <= '0;
            ra      <= mw_go ? n_m2 : '0;
            sum     <= 16'd0;
            acc     <= 64'd0;
            pos     <= 7'd0;
            if (req.cmd == CMD_READ) begin
              state <= (n == '0) ? S_DONE : S_WT;
            end else if (same) begin
              last_len <= inc_len;
              last_mod <= inc_mod;
              if (!sync) begin
                win_len[wn_m1] <= inc_len;
                state <= S_DONE;
              end else if (n > NW'(2)) begin
                state <= S_MW1;
              end else begin
                state <= (inc_mod == 4'd0) ? S_WT : S_DONE;
              end
            end else if (!sync) begin
              // Window: append, or drop the oldest run
              if (n < NW'(WIN_RUNS)) begin
                win_len[2'(n)] <= 16'd1;
                win_lvl[2'(n)] <= s_lvl;
                n <= n + NW'(1);
              end else begin
                for (int i = 0; i < WIN_RUNS - 1; i++) begin
                  win_len[i] <= win_len[i + 1];
                  win_lvl[i] <= win_lvl[i + 1];
                end
                win_len[WIN_RUNS-1] <= 16'd1;
                win_lvl[WIN_RUNS-1] <= s_lvl;
              end
              last_len <= 16'd1;
              last_lvl <= s_lvl;
              last_mod <= 4'd1;
              state    <= S_SYNC;
            end else begin
              app   <= 1'b1;
              state <= S_WT;
            end
          end
        end
        S_MW1: begin
          ra    <= n_m3;
          state <= S_MW2;
        end
        S_MW2: begin
          m2_len <= rd_q[15:0];
          state  <= S_MW3;
        end
        S_MW3: begin
          if (m2_len < min_spk) begin
            // Merge the last two runs into the one before them
            n        <= n - NW'(2);
            last_len <= msat;
            last_lvl <= rd_q[16];
            div_mod  <= 1'b1;
            dv_quo   <= {2'd0, msat};
            dv_den   <= 9'd10;
            dv_rem   <= 10'd0;
            dv_cnt   <= 5'd0;
            state    <= S_DIV;
          end else begin
            ra    <= '0;
            state <= (last_mod == 4'd0) ? S_WT : S_DONE;
          end
        end
        S_WT: begin
          state <= S_LD;
        end
        S_LD: begin
          cur_lvl <= src[16];
          dv_quo  <= {1'b0, src[15:0], 1'b0} + {10'd0, blen};
          dv_den  <= {blen, 1'b0};
          dv_rem  <= 10'd0;
          dv_cnt  <= 5'd0;
          state   <= S_DIV;
        end
        S_DIV: begin
          dv_rem <= dv_rn;
          dv_quo <= dv_qn;
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'd17) begin
            if (div_mod) begin
              last_mod <= dv_rn[3:0];
              div_mod  <= 1'b0;
              ra       <= '0;
              state    <= S_WT;
            end else begin
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (is_read) begin
            if (cur_lvl) begin
              acc <= acc | fmask;
            end
            pos <= pos_n;
          end else begin
            sum <= sum_n;
          end
          if (w_last) begin
            if (is_read) begin
              state <= S_DONE;
            end else begin
              total <= sum_n;
              state <= app ? S_APPEND : S_DONE;
            end
          end else begin
            idx   <= idx + IW'(1);
            ra    <= idx + IW'(1);
            state <= S_WT;
          end
        end
        S_APPEND: begin
          if (n < NW'(MAX_RUNS)) begin
            n        <= n + NW'(1);
            last_len <= 16'd1;
            last_lvl <= in_lvl;
            last_mod <= 4'd1;
          end else begin
            ovf <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SYNC: begin
          if (sync_hit) begin
            sync  <= 1'b1;
            ra    <= '0;
            state <= S_COPY;
          end else begin
            state <= S_DONE;
          end
        end
        S_COPY: begin
          ra <= ra + IW'(1);
          if (ra == IW'(WIN_RUNS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_out) begin
            rsp_q.synced         <= sync;
            rsp_q.bit_count      <= total;
            rsp_q.run_overflow   <= ovf;
            rsp_q.frame_bits     <= is_read ? acc : 64'd0;
            rsp_q.frame_len      <= is_read ? pos : 7'd0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_sync_sticky: assert property (@(posedge clk) disable iff (rst) sync |=> sync)
    else $error("sync dropped");
  a_runs_bound: assert property (@(posedge clk) disable iff (rst) n <= NW'(MAX_RUNS))
    else $error("run count above store size");
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    !sync |-> n <= NW'(WIN_RUNS))
    else $error("window holds too many runs");
  a_ovf_after_sync: assert property (@(posedge clk) disable iff (rst) ovf |-> sync)
    else $error("overflow before sync");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import trfd_pkg::*;

  localparam int RUN_SLOTS  = 64;
  localparam int FRAME_MAX  = 64;
  localparam int WATCHDOG   = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  threshold_run_frame_detector_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // detector shadow state
  logic [15:0] thr_q, min_spk_q, max_spk_q;
  logic [7:0]  zero_len_q, one_len_q;
  logic [15:0] run_cnt [RUN_SLOTS];
  logic        run_lvl [RUN_SLOTS];
  int          runs_held;
  logic        is_synced, ovf_seen;
  logic [15:0] total_q;

  rsp_t expected_rsps [$];
  int   errors = 0;
  int   sender_idle = 0, receiver_idle = 0;
  bit   hold_rx = 1'b0;
  int   quiet_cycles = 0;

  function automatic int bits_in_run(int i);
    int len;
    len = run_lvl[i] ? one_len_q : zero_len_q;
    if (len == 0) len = 1;
    return (2 * run_cnt[i] + len) / (2 * len);
  endfunction

  function automatic void sum_bits();
    int s;
    s = 0;
    if (!is_synced) return;
    for (int i = 0; i < runs_held; i++) begin
      s += bits_in_run(i);
      if (s > 65535) s = 65535;
    end
    total_q = s[15:0];
  endfunction

  function automatic bit merge_spike();
    int s;
    s = 0;
    if (runs_held <= 2) return 1'b0;
    if (run_cnt[runs_held-2] >= min_spk_q) return 1'b0;
    s = run_cnt[runs_held-3] + run_cnt[runs_held-2] + run_cnt[runs_held-1];
    if (s > 65535) s = 65535;
    run_cnt[runs_held-3] = s[15:0];
    run_cnt[runs_held-2] = '0; run_lvl[runs_held-2] = 1'b0;
    run_cnt[runs_held-1] = '0; run_lvl[runs_held-1] = 1'b0;
    runs_held -= 2;
    return 1'b1;
  endfunction

  function automatic bit spike_ok(logic [15:0] c);
    return c > min_spk_q && c < max_spk_q;
  endfunction

  function automatic void shadow_reset();
    thr_q = THR_RST; min_spk_q = MIN_SPK_RST; max_spk_q = MAX_SPK_RST;
    zero_len_q = ZERO_LEN_RST; one_len_q = ONE_LEN_RST;
    for (int i = 0; i < RUN_SLOTS; i++) begin
      run_cnt[i] = '0; run_lvl[i] = 1'b0;
    end
    runs_held = 0; is_synced = 1'b0; ovf_seen = 1'b0; total_q = '0;
  endfunction

  // Advance the shadow detector by one item and return the result it yields
  function automatic rsp_t detect_step(req_t r);
    rsp_t o;
    logic lvl;
    int last, n, pos;
    bit merged;
    o = '0;
    if (r.cmd == CMD_FEED) begin
      lvl = r.sample > thr_q;
      if (runs_held > 0 && run_lvl[runs_held-1] == lvl) begin
        last = runs_held - 1;
        merged = 1'b0;
        if (run_cnt[last] != COUNT_MAX) run_cnt[last]++;
        if (is_synced) merged = merge_spike();
        if (merged || run_cnt[last] % 10 == 0) sum_bits();
      end else if (!is_synced) begin
        if (runs_held < WIN_RUNS) begin
          run_cnt[runs_held] = 16'd1; run_lvl[runs_held] = lvl; runs_held++;
        end else begin
          for (int i = 0; i < WIN_RUNS - 1; i++) begin
            run_cnt[i] = run_cnt[i+1]; run_lvl[i] = run_lvl[i+1];
          end
          run_cnt[WIN_RUNS-1] = 16'd1; run_lvl[WIN_RUNS-1] = lvl;
        end
        if (runs_held == WIN_RUNS && run_lvl[0] && !run_lvl[1] && run_lvl[2] &&
            spike_ok(run_cnt[0]) && spike_ok(run_cnt[1]) && spike_ok(run_cnt[2]))
          is_synced = 1'b1;
      end else begin
        sum_bits();
        if (runs_held < RUN_SLOTS) begin
          run_cnt[runs_held] = 16'd1; run_lvl[runs_held] = lvl; runs_held++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
    end else begin
      pos = 0;
      for (int i = 0; i < runs_held; i++) begin
        n = bits_in_run(i);
        if (n > FRAME_MAX - pos) n = FRAME_MAX - pos;
        for (int k = 0; k < n; k++) begin
          if (run_lvl[i]) o.frame_bits[pos] = 1'b1;
          pos++;
        end
        if (pos >= FRAME_MAX) break;
      end
      o.frame_len = pos[6:0];
    end
    o.synced = is_synced;
    o.bit_count = total_q;
    o.run_overflow = ovf_seen;
    return o;
  endfunction

  // Register write over the config port, block idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LEVEL_THRESHOLD: thr_q = val[15:0];
      REG_MIN_SPIKE_LEN:   min_spk_q = val[15:0];
      REG_MAX_SPIKE_LEN:   max_spk_q = val[15:0];
      REG_ZERO_BIT_LEN:    zero_len_q = val[7:0];
      REG_ONE_BIT_LEN:     one_len_q = val[7:0];
      default: ;
    endcase
  endtask

  // Offer one item, hold until accepted; queue its expectation.
  // Valid stays high after acceptance so the next item can follow at once.
  task automatic send_item(logic c, logic [15:0] s, bit fixed, rsp_t want);
    rsp_t pred;
    int idle;
    idle = 0;
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) idle++;
    if (idle > 0) begin
      req_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.cmd <= c;
    req.sample <= s;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = detect_step('{cmd: c, sample: s});
    if (fixed && pred !== want) begin
      $error("directed row mismatch: expected %h predicted %h", want, pred);
      errors++;
    end
    expected_rsps.push_back(pred);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (40 * RUN_SLOTS) @(posedge clk);
  endtask

  // Preamble 1,0,1 then random body, mostly synced frames
  task automatic send_frame(int nruns);
    logic lvl;
    int len;
    lvl = 1'b1;
    for (int r = 0; r < 4; r++) begin
      len = (r < 3) ? $urandom_range(int'(max_spk_q) - 1, int'(min_spk_q) + 1)
                    : $urandom_range(8, 1);
      for (int k = 0; k < len; k++)
        send_item(CMD_FEED, lvl ? 16'(thr_q + 1 + $urandom_range(100)) :
                  16'($urandom_range(int'(thr_q))), 1'b0, '0);
      lvl = ~lvl;
    end
    for (int r = 0; r < nruns; r++) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(14, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(15) == 0)
          send_item(CMD_READ, 16'($urandom), 1'b0, '0);
        send_item(CMD_FEED, lvl ? 16'(thr_q + 1 + $urandom_range(100)) :
                  16'($urandom_range(int'(thr_q))), 1'b0, '0);
      end
      lvl = ~lvl;
    end
    send_item(CMD_READ, 16'($urandom), 1'b0, '0);
  endtask

  typedef struct {
    logic        cmd;
    logic [15:0] sample;
    bit          fixed;
    rsp_t        want;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{CMD_READ, 16'hFFFF, 1'b1, '0},
    '{CMD_FEED, 16'h0000, 1'b1, '0},
    '{CMD_READ, 16'h0000, 1'b0, '0},
    '{CMD_FEED, 16'hFFFF, 1'b1, '0},
    '{CMD_FEED, 16'h0000, 1'b1, '0},
    '{CMD_FEED, 16'h0001, 1'b1, '0},
    '{CMD_FEED, 16'h0001, 1'b1, '0},
    '{CMD_FEED, 16'h0000, 1'b0, '0},
    '{CMD_FEED, 16'h8000, 1'b0, '0},
    '{CMD_FEED, 16'h5555, 1'b0, '0},
    '{CMD_FEED, 16'hAAAA, 1'b0, '0},
    '{CMD_READ, 16'h0000, 1'b0, '0}
  };

  // Response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %h", rsp);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.synced !== want.synced) begin
          $error("synced: expected %0d actual %0d", want.synced, rsp.synced); errors++;
        end
        if (rsp.bit_count !== want.bit_count) begin
          $error("bit_count: expected %0d actual %0d", want.bit_count, rsp.bit_count);
          errors++;
        end
        if (rsp.run_overflow !== want.run_overflow) begin
          $error("run_overflow: expected %0d actual %0d", want.run_overflow,
                 rsp.run_overflow); errors++;
        end
        if (rsp.frame_bits !== want.frame_bits) begin
          $error("frame_bits: expected %h actual %h", want.frame_bits, rsp.frame_bits);
          errors++;
        end
        if (rsp.frame_len !== want.frame_len) begin
          $error("frame_len: expected %0d actual %0d", want.frame_len, rsp.frame_len);
          errors++;
        end
      end
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_rx) rsp_stall <= 1'b1;
    else rsp_stall <= receiver_idle > 0 && $urandom_range(99) < receiver_idle;
  end

  initial begin
    int hold;
    @(posedge clk);
    wait (hold_rx);
    for (hold = 0; hold < 600; hold++) @(posedge clk);
    hold_rx = 1'b0;
  end

  // Watchdog on stretches with no accepted item, taken result or register access
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, levels, extremes
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].sample, directed[i].fixed,
                directed[i].want);
    drain();

    // Sync under defaults, then fill the store to overflow
    send_frame(70);
    drain();

    // Phase 1: sender idles a little, receiver a lot; new settings each frame
    sender_idle = 15; receiver_idle = 76;
    for (int f = 0; f < 3; f++) begin
      rst <= 1'b0;
      write_reg(REG_LEVEL_THRESHOLD, $urandom_range(1000, 10));
      write_reg(REG_MIN_SPIKE_LEN, $urandom_range(3, 0));
      write_reg(REG_MAX_SPIKE_LEN, $urandom_range(12, 6));
      write_reg(REG_ZERO_BIT_LEN, $urandom_range(6, 1));
      write_reg(REG_ONE_BIT_LEN, $urandom_range(6, 1));
      send_frame(20);
      drain();
    end

    // Phase 2: the other way round, extremes of bit lengths and threshold
    sender_idle = 76; receiver_idle = 15;
    write_reg(REG_ZERO_BIT_LEN, 32'd0);
    write_reg(REG_ONE_BIT_LEN, 32'd255);
    write_reg(REG_LEVEL_THRESHOLD, 32'hFFFE);
    for (int k = 0; k < 60; k++)
      send_item(CMD_FEED, 16'($urandom), 1'b0, '0);
    send_item(CMD_READ, 16'hFFFF, 1'b0, '0);
    drain();
    write_reg(REG_MIN_SPIKE_LEN, 32'hFFFF);
    write_reg(REG_MAX_SPIKE_LEN, 32'h0000);
    write_reg(REG_LEVEL_THRESHOLD, 32'h0000);
    for (int k = 0; k < 60; k++)
      send_item($urandom_range(7) == 0, 16'($urandom), 1'b0, '0);
    drain();

    // Phase 3: no idling, long receiver hold-off under load
    sender_idle = 0; receiver_idle = 0;
    write_reg(REG_ZERO_BIT_LEN, 32'd255);
    write_reg(REG_ONE_BIT_LEN, 32'd1);
    hold_rx = 1'b1;
    for (int k = 0; k < 200; k++)
      send_item($urandom_range(15) == 0, 16'($urandom), 1'b0, '0);
    drain();

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/trfd_pkg.sv
src/threshold_run_frame_detector_top.sv
sim/tb.sv
